### hw/rtl/ptrd_pkg.sv
// shared types, codes and constants for the pulse train sequencer
// no dependencies; imported by every other file of the block
`default_nettype none

package ptrd_pkg;

   // default values of the top level parameters
   localparam int COUNT_WIDTH_DEF = 24;
   localparam int FRAC_BITS_DEF   = 8;
   localparam int PWM_TOP_DEF     = 800;

   // fixed field widths
   localparam int OPCODE_W   = 2;
   localparam int STEPS_W    = 10;
   localparam int POWER_W    = 7;
   localparam int CMP_W      = 10;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // on level is power times eight
   localparam int POWER_SCALE_SHIFT = 3;
   localparam int POWER_LIMIT       = 100;

   // request opcodes
   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK        = 2'd0,
      OP_START       = 2'd1,
      OP_CANCEL      = 2'd2,
      OP_CANCEL_RAMP = 2'd3
   } opcode_type;

   // register word index (byte address / 4)
   typedef enum logic [2:0] {
      IDX_DURATION    = 3'd0,
      IDX_PRE_DELAY   = 3'd1,
      IDX_PULSE_WIDTH = 3'd2,
      IDX_PERIOD      = 3'd3,
      IDX_POWER       = 3'd4,
      IDX_RAMP_ENABLE = 3'd5,
      IDX_RAMP_STEPS  = 3'd6,
      IDX_UNUSED      = 3'd7
   } csr_index_type;

   // divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

`default_nettype wire

### hw/rtl/ptrd_csr.sv
// configuration register file with an apb style access port
// depends on ptrd_pkg
`default_nettype none

module ptrd_csr #(
   parameter int COUNT_WIDTH = ptrd_pkg::COUNT_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [ptrd_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [ptrd_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [ptrd_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output logic [COUNT_WIDTH-1:0]              duration_ticks,
   output logic [COUNT_WIDTH-1:0]              pre_delay_ticks,
   output logic [COUNT_WIDTH-1:0]              pulse_width_ticks,
   output logic [COUNT_WIDTH-1:0]              period_ticks,
   output logic [ptrd_pkg::POWER_W-1:0]        power_percent,
   output logic                                ramp_enable,
   output logic [ptrd_pkg::STEPS_W-1:0]        ramp_steps
);
   import ptrd_pkg::*;

   logic [COUNT_WIDTH-1:0] duration_ff,    duration_in;
   logic [COUNT_WIDTH-1:0] pre_delay_ff,   pre_delay_in;
   logic [COUNT_WIDTH-1:0] width_ff,       width_in;
   logic [COUNT_WIDTH-1:0] period_ff,      period_in;
   logic [POWER_W-1:0]     power_ff,       power_in;
   logic                   ramp_enable_ff, ramp_enable_in;
   logic [STEPS_W-1:0]     ramp_steps_ff,  ramp_steps_in;

   csr_index_type index;
   logic          wr_en;

   assign index  = csr_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;

   // register write decode
   always_comb begin
      duration_in    = duration_ff;
      pre_delay_in   = pre_delay_ff;
      width_in       = width_ff;
      period_in      = period_ff;
      power_in       = power_ff;
      ramp_enable_in = ramp_enable_ff;
      ramp_steps_in  = ramp_steps_ff;
      if (wr_en) begin
         case (index)
            IDX_DURATION:    duration_in    = pwdata[COUNT_WIDTH-1:0];
            IDX_PRE_DELAY:   pre_delay_in   = pwdata[COUNT_WIDTH-1:0];
            IDX_PULSE_WIDTH: width_in       = pwdata[COUNT_WIDTH-1:0];
            IDX_PERIOD:      period_in      = pwdata[COUNT_WIDTH-1:0];
            IDX_POWER:       power_in       = pwdata[POWER_W-1:0];
            IDX_RAMP_ENABLE: ramp_enable_in = pwdata[0];
            IDX_RAMP_STEPS:  ramp_steps_in  = pwdata[STEPS_W-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (index)
         IDX_DURATION:    prdata = CSR_DATA_W'(duration_ff);
         IDX_PRE_DELAY:   prdata = CSR_DATA_W'(pre_delay_ff);
         IDX_PULSE_WIDTH: prdata = CSR_DATA_W'(width_ff);
         IDX_PERIOD:      prdata = CSR_DATA_W'(period_ff);
         IDX_POWER:       prdata = CSR_DATA_W'(power_ff);
         IDX_RAMP_ENABLE: prdata = CSR_DATA_W'(ramp_enable_ff);
         IDX_RAMP_STEPS:  prdata = CSR_DATA_W'(ramp_steps_ff);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duration_ff    <= '0;
         pre_delay_ff   <= '0;
         width_ff       <= '0;
         period_ff      <= '0;
         power_ff       <= '0;
         ramp_enable_ff <= 1'b0;
         ramp_steps_ff  <= '0;
      end else begin
         duration_ff    <= duration_in;
         pre_delay_ff   <= pre_delay_in;
         width_ff       <= width_in;
         period_ff      <= period_in;
         power_ff       <= power_in;
         ramp_enable_ff <= ramp_enable_in;
         ramp_steps_ff  <= ramp_steps_in;
      end
   end

   assign duration_ticks    = duration_ff;
   assign pre_delay_ticks   = pre_delay_ff;
   assign pulse_width_ticks = width_ff;
   assign period_ticks      = period_ff;
   assign power_percent     = power_ff;
   assign ramp_enable       = ramp_enable_ff;
   assign ramp_steps        = ramp_steps_ff;

endmodule

`default_nettype wire

### hw/rtl/ptrd_div.sv
// serial restoring divider, one quotient bit per cycle
// depends on ptrd_pkg; a zero divisor gives a zero quotient
`default_nettype none

module ptrd_div #(
   parameter int DIVIDEND_W = 18,
   parameter int DIVISOR_W  = ptrd_pkg::STEPS_W
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_W-1:0]    dividend,
   input  logic [DIVISOR_W-1:0]     divisor,
   output logic [DIVIDEND_W-1:0]    quotient,
   output ptrd_pkg::div_stat_type   stat
);
   import ptrd_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff,  cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff,  quo_in;
   logic [DIVISOR_W-1:0]  rem_ff,  rem_in;
   logic [DIVISOR_W-1:0]  den_ff,  den_in;

   logic [DIVISOR_W:0]    rem_sh;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // trial subtract of the shifted remainder
   assign rem_sh = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff   = rem_sh - {1'b0, den_ff};
   assign fits   = (rem_sh >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient  = (den_ff == '0) ? '0 : quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

`default_nettype wire

### hw/rtl/pulse_train_with_ramp_down.sv
// pulse train sequencer with ramp-down: request sequencer and timing datapath
// depends on ptrd_pkg, ptrd_csr, ptrd_div
//
// Usage: each request word carries an opcode (tick, start, cancel now, cancel
// with ramp-down) and a step count for the ramped cancel. Every request word
// yields exactly one response word: the current pwm compare value, the running
// flag and a start error flag. Both channels move a word at a clock edge where
// valid is high and stall is low.
// Request flow: a tick while running passes ST_TICK_INC, ST_TICK_EVAL and ST_DONE;
// a tick while idle and a cancel go straight to ST_DONE; a start without ramp
// passes ST_START_LOAD, ST_START_TIME and ST_DONE (ST_START_TIME is skipped when
// rejected or the duration is zero). A start with ramp enabled and a ramped cancel
// first wait in ST_DIV on the serial divider (one quotient bit per cycle, LEVEL_W =
// 10 + FRAC_BITS quotient bits). One request
// is in work at a time; req_stall is high until its response has been loaded
// into the output register.
// A stalled response holds in the output register while the next request is
// accepted and processed; that request's response waits until the register
// frees.
// Reset (synchronous, active high) clears the state, flags, timing state and the
// response valid flag, not the response data; the block is ready once it is released.
`default_nettype none

module pulse_train_with_ramp_down #(
   parameter int COUNT_WIDTH = ptrd_pkg::COUNT_WIDTH_DEF,
   parameter int FRAC_BITS   = ptrd_pkg::FRAC_BITS_DEF,
   parameter int PWM_TOP     = ptrd_pkg::PWM_TOP_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [ptrd_pkg::OPCODE_W-1:0]    req_opcode,
   input  logic [ptrd_pkg::STEPS_W-1:0]     req_cancel_steps,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [ptrd_pkg::CMP_W-1:0]       rsp_pwm_compare,
   output logic                             rsp_pulse_active,
   output logic                             rsp_start_error,
   // configuration port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ptrd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ptrd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ptrd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import ptrd_pkg::*;

   localparam int CW      = COUNT_WIDTH;
   localparam int WW      = COUNT_WIDTH + 1;
   localparam int LEVEL_W = POWER_W + POWER_SCALE_SHIFT + FRAC_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK_INC,
      ST_TICK_EVAL,
      ST_DIV,
      ST_START_LOAD,
      ST_START_TIME,
      ST_DONE
   } state_type;

   // configuration
   logic [CW-1:0]      cfg_duration;
   logic [CW-1:0]      cfg_pre_delay;
   logic [CW-1:0]      cfg_width;
   logic [CW-1:0]      cfg_period;
   logic [POWER_W-1:0] cfg_power;
   logic               cfg_ramp_enable;
   logic [STEPS_W-1:0] cfg_ramp_steps;

   ptrd_csr #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_csr (
      .clock             (clock),
      .reset             (reset),
      .psel              (csr_psel),
      .penable           (csr_penable),
      .pwrite            (csr_pwrite),
      .paddr             (csr_paddr),
      .pwdata            (csr_pwdata),
      .prdata            (csr_prdata),
      .pready            (csr_pready),
      .duration_ticks    (cfg_duration),
      .pre_delay_ticks   (cfg_pre_delay),
      .pulse_width_ticks (cfg_width),
      .period_ticks      (cfg_period),
      .power_percent     (cfg_power),
      .ramp_enable       (cfg_ramp_enable),
      .ramp_steps        (cfg_ramp_steps)
   );

   // sequencer and datapath registers
   state_type          state_ff,        state_in;
   opcode_type         op_ff,           op_in;
   logic [STEPS_W-1:0] csteps_ff,       csteps_in;
   logic               running_ff,      running_in;
   logic               phase_on_ff,     phase_on_in;
   logic               ramp_armed_ff,   ramp_armed_in;
   logic [WW-1:0]      elapsed_ff,      elapsed_in;
   logic [CW-1:0]      live_pre_ff,     live_pre_in;
   logic [CW-1:0]      live_dur_ff,     live_dur_in;
   logic [WW-1:0]      live_end_ff,     live_end_in;
   logic [WW-1:0]      next_flip_ff,    next_flip_in;
   logic [CW-1:0]      live_on_ff,      live_on_in;
   logic [CW-1:0]      live_off_ff,     live_off_in;
   logic [LEVEL_W-1:0] level_ff,        level_in;
   logic [LEVEL_W-1:0] ramp_step_ff,    ramp_step_in;
   logic [STEPS_W-1:0] ramp_done_ff,    ramp_done_in;
   logic [STEPS_W-1:0] ramp_limit_ff,   ramp_limit_in;
   logic [CMP_W-1:0]   compare_ff,      compare_in;
   logic               err_ff,          err_in;
   logic               rsp_valid_ff,    rsp_valid_in;
   logic [CMP_W-1:0]   rsp_compare_ff,  rsp_compare_in;
   logic               rsp_active_ff,   rsp_active_in;
   logic               rsp_error_ff,    rsp_error_in;

   // shared divider
   logic               div_start;
   logic [LEVEL_W-1:0] div_dividend;
   logic [STEPS_W-1:0] div_divisor;
   logic [LEVEL_W-1:0] div_quotient;
   div_stat_type       div_stat;

   ptrd_div #(
      .DIVIDEND_W (LEVEL_W),
      .DIVISOR_W  (STEPS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .stat     (div_stat)
   );

   // integer part of a level, clamped to the pwm top
   function automatic logic [CMP_W-1:0] show_level(input logic [LEVEL_W-1:0] lv);
      logic [CMP_W-1:0] v;
      v = lv[LEVEL_W-1:FRAC_BITS];
      if (32'(v) > 32'(PWM_TOP))
         return CMP_W'(PWM_TOP);
      return v;
   endfunction

   logic               req_accept;
   logic [LEVEL_W-1:0] on_level;
   logic [WW-1:0]      elapsed_inc;
   logic [WW:0]        flip_sum;
   logic [WW-1:0]      flip_sat;
   logic [LEVEL_W-1:0] level_dec;
   logic               before_pre;
   logic               at_pre;
   logic               in_train;
   logic               before_flip;
   logic               ramp_go;
   logic               stop_now;

   assign req_accept = req_valid & ~req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign on_level   = {cfg_power, {POWER_SCALE_SHIFT{1'b0}}, {FRAC_BITS{1'b0}}};

   // tick arithmetic: saturating counters, window compares, ramp step
   assign elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;
   assign flip_sum    = {1'b0, next_flip_ff}
                        + (WW+1)'(phase_on_ff ? live_off_ff : live_on_ff);
   assign flip_sat    = flip_sum[WW] ? '1 : flip_sum[WW-1:0];
   assign level_dec   = level_ff - ramp_step_ff;
   assign before_pre  = (elapsed_ff < WW'(live_pre_ff));
   assign at_pre      = (elapsed_ff == WW'(live_pre_ff));
   assign in_train    = (elapsed_ff < live_end_ff);
   assign before_flip = (elapsed_ff < next_flip_ff);
   assign ramp_go     = ramp_armed_ff && (level_ff > ramp_step_ff)
                        && (ramp_done_ff < ramp_limit_ff);

   // divider operands are selected by the request opcode
   assign div_start    = req_accept && ((opcode_type'(req_opcode) == OP_CANCEL_RAMP)
                         || ((opcode_type'(req_opcode) == OP_START) && cfg_ramp_enable));
   assign div_dividend = (opcode_type'(req_opcode) == OP_START) ? on_level : level_ff;
   assign div_divisor  = (opcode_type'(req_opcode) == OP_START) ? cfg_ramp_steps
                                                                 : req_cancel_steps;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      csteps_in      = csteps_ff;
      running_in     = running_ff;
      phase_on_in    = phase_on_ff;
      ramp_armed_in  = ramp_armed_ff;
      elapsed_in     = elapsed_ff;
      live_pre_in    = live_pre_ff;
      live_dur_in    = live_dur_ff;
      live_end_in    = live_end_ff;
      next_flip_in   = next_flip_ff;
      live_on_in     = live_on_ff;
      live_off_in    = live_off_ff;
      level_in       = level_ff;
      ramp_step_in   = ramp_step_ff;
      ramp_done_in   = ramp_done_ff;
      ramp_limit_in  = ramp_limit_ff;
      compare_in     = compare_ff;
      err_in         = err_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_compare_in = rsp_compare_ff;
      rsp_active_in  = rsp_active_ff;
      rsp_error_in   = rsp_error_ff;
      stop_now       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in     = opcode_type'(req_opcode);
               csteps_in = req_cancel_steps;
               err_in    = 1'b0;
               case (opcode_type'(req_opcode))
                  OP_TICK:   state_in = running_ff ? ST_TICK_INC : ST_DONE;
                  OP_START:  state_in = cfg_ramp_enable ? ST_DIV : ST_START_LOAD;
                  OP_CANCEL: begin
                     stop_now = 1'b1;
                     state_in = ST_DONE;
                  end
                  OP_CANCEL_RAMP: state_in = ST_DIV;
                  default:        state_in = ST_DONE;
               endcase
            end
         end

         ST_TICK_INC: begin
            elapsed_in = elapsed_inc;
            state_in   = ST_TICK_EVAL;
         end

         // one tick of the train: pre-delay, on/off phases, ramp, stop
         ST_TICK_EVAL: begin
            if (!before_pre) begin
               if (at_pre)
                  compare_in = show_level(level_ff);
               if (in_train) begin
                  if (!before_flip) begin
                     if (phase_on_ff && (live_off_ff != '0)) begin
                        phase_on_in  = 1'b0;
                        next_flip_in = flip_sat;
                        compare_in   = '0;
                     end else if (!phase_on_ff && (live_on_ff != '0)) begin
                        phase_on_in  = 1'b1;
                        next_flip_in = flip_sat;
                        compare_in   = show_level(level_ff);
                     end
                  end
               end else if (ramp_go) begin
                  level_in     = level_dec;
                  compare_in   = show_level(level_dec);
                  ramp_done_in = ramp_done_ff + 1'b1;
               end else begin
                  stop_now = 1'b1;
               end
            end
            state_in = ST_DONE;
         end

         // wait for the ramp step quotient, then arm the ramp
         ST_DIV: begin
            if (div_stat.done) begin
               ramp_step_in  = div_quotient;
               ramp_done_in  = '0;
               ramp_armed_in = 1'b1;
               if (op_ff == OP_START) begin
                  ramp_limit_in = cfg_ramp_steps;
                  state_in      = ST_START_LOAD;
               end else begin
                  ramp_limit_in = csteps_ff;
                  live_pre_in   = '0;
                  live_dur_in   = '0;
                  live_end_in   = '0;
                  state_in      = ST_DONE;
               end
            end
         end

         ST_START_LOAD: begin
            state_in = ST_DONE;
            if (32'(cfg_power) > 32'(POWER_LIMIT)) begin
               err_in = 1'b1;
            end else begin
               level_in = on_level;
               if (cfg_duration != '0) begin
                  live_dur_in = cfg_duration;
                  live_pre_in = cfg_pre_delay;
                  live_on_in  = cfg_width;
                  live_off_in = (cfg_period > cfg_width) ? cfg_period - cfg_width : '0;
                  live_end_in = WW'(cfg_pre_delay) + WW'(cfg_duration);
                  phase_on_in = 1'b1;
                  running_in  = 1'b1;
                  state_in    = ST_START_TIME;
               end
            end
         end

         ST_START_TIME: begin
            next_flip_in = WW'(live_pre_ff) + WW'(live_on_ff);
            if (live_pre_ff == '0)
               compare_in = show_level(level_ff);
            state_in = ST_DONE;
         end

         // hand the response to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_compare_in = compare_ff;
               rsp_active_in  = running_ff;
               rsp_error_in   = err_ff;
               state_in       = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // stop: the running flag, compare value and all timing and ramp state clear; the phase flag does not
      if (stop_now) begin
         running_in    = 1'b0;
         compare_in    = '0;
         elapsed_in    = '0;
         live_pre_in   = '0;
         live_dur_in   = '0;
         live_end_in   = '0;
         next_flip_in  = '0;
         live_on_in    = '0;
         live_off_in   = '0;
         level_in      = '0;
         ramp_step_in  = '0;
         ramp_done_in  = '0;
         ramp_limit_in = '0;
         ramp_armed_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         running_ff    <= 1'b0;
         phase_on_ff   <= 1'b0;
         ramp_armed_ff <= 1'b0;
         elapsed_ff    <= '0;
         live_pre_ff   <= '0;
         live_dur_ff   <= '0;
         live_end_ff   <= '0;
         next_flip_ff  <= '0;
         live_on_ff    <= '0;
         live_off_ff   <= '0;
         level_ff      <= '0;
         ramp_step_ff  <= '0;
         ramp_done_ff  <= '0;
         ramp_limit_ff <= '0;
         compare_ff    <= '0;
         err_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         running_ff    <= running_in;
         phase_on_ff   <= phase_on_in;
         ramp_armed_ff <= ramp_armed_in;
         elapsed_ff    <= elapsed_in;
         live_pre_ff   <= live_pre_in;
         live_dur_ff   <= live_dur_in;
         live_end_ff   <= live_end_in;
         next_flip_ff  <= next_flip_in;
         live_on_ff    <= live_on_in;
         live_off_ff   <= live_off_in;
         level_ff      <= level_in;
         ramp_step_ff  <= ramp_step_in;
         ramp_done_ff  <= ramp_done_in;
         ramp_limit_ff <= ramp_limit_in;
         compare_ff    <= compare_in;
         err_ff        <= err_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff          <= op_in;
      csteps_ff      <= csteps_in;
      rsp_compare_ff <= rsp_compare_in;
      rsp_active_ff  <= rsp_active_in;
      rsp_error_ff   <= rsp_error_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pwm_compare  = rsp_compare_ff;
   assign rsp_pulse_active = rsp_active_ff;
   assign rsp_start_error  = rsp_error_ff;

   // the divider only reports completion while the sequencer waits on it
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIV))
      else $error("divider completed outside the divide step");

   // a sequencer that is not running always drives a zero compare value
   a_idle_compare_zero: assert property (@(posedge clock) disable iff (reset)
      !running_ff |-> (compare_ff == '0))
      else $error("compare value nonzero while not running");

   // ramp progress never passes its limit
   a_ramp_bounded: assert property (@(posedge clock) disable iff (reset)
      ramp_done_ff <= ramp_limit_ff)
      else $error("ramp step count beyond its limit");

   // an accepted word always leaves the idle state
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != ST_IDLE))
      else $error("request accepted without starting work");

endmodule

`default_nettype wire
